// ===== design/hec_pkg.sv =====
// shared types, character constants and helper functions for the hex escape codec
package hec_pkg;

    localparam int MAX_OUT = 4;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);
    localparam int IDX_W   = $clog2(MAX_OUT);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    // decode progress through a backslash-x escape
    typedef enum logic [1:0] {
        HELD_IDLE  = 2'd0,
        HELD_BS    = 2'd1,
        HELD_BSX   = 2'd2,
        HELD_DIGIT = 2'd3
    } held_e_t;

    typedef struct packed {
        held_e_t     count;
        logic [3:0]  nibble;
        logic [7:0]  digit_byte;
    } held_t;

    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [CNT_W-1:0]        cnt;
        logic                    last;
    } res_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hexv_t;

    function automatic res_t push(res_t r, logic [7:0] b);
        res_t o;
        o = r;
        if (r.cnt < CNT_W'(MAX_OUT))
        begin
            o.bytes[r.cnt[IDX_W-1:0]] = b;
            o.cnt = r.cnt + CNT_W'(1);
        end
        return o;
    endfunction

    function automatic logic passes(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A) || c == CH_COLON || c == CH_UNDER ||
               c == CH_DOT;
    endfunction

    function automatic hexv_t hex_val(logic [7:0] c);
        hexv_t      h;
        logic [7:0] d;
        h = '0;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
            h.ok = 1'b1;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h57;
            h.ok = 1'b1;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
            h.ok = 1'b1;
        end
        h.val = d[3:0];
        return h;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
            c = 8'h30 + {4'd0, n};
        else
            c = 8'h57 + {4'd0, n};
        return c;
    endfunction

endpackage

// ===== design/hex_escape_codec.sv =====
// top level of the backslash-x hex escape codec
//
//  channel  | signals                          | role
//  ---------+----------------------------------+--------------------------------
//  cfg      | cfg_valid cfg_ready direction    | direction write, 0 encode 1 decode
//  in       | in_valid in_ready in_byte in_last| one input byte per transfer
//  out      | out_valid out_ready out_byte ... | one output byte per transfer
//
// an input byte is translated in the cycle it is accepted and its 0 to 4 output
// bytes land in the result register; they leave one per cycle while out is ready.
// the next input is taken as the last pending byte transfers, or at once if none.
// reset clears the direction, the held escape state and the result count and index.
// a stall on out holds the pending bytes and back-pressures in.
module hex_escape_codec
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       direction,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic           dir_reg;
    hec_pkg::held_t held_reg, held_next;
    hec_pkg::res_t  res;
    logic           in_xfer;

    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= 1'b0;
            held_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                dir_reg <= direction;
            if (in_xfer)
                held_reg <= held_next;
        end
    end

    hec_xlate u_xlate
    (
        .direction (dir_reg),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .held      (held_reg),
        .held_next (held_next),
        .res       (res)
    );

    hec_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_xfer),
        .res        (res),
        .load_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

endmodule

// ===== design/hec_xlate.sv =====
// per-byte translation: expands one input byte into up to four output bytes
module hec_xlate
(
    input  logic               direction,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  hec_pkg::held_t     held,
    output hec_pkg::held_t     held_next,
    output hec_pkg::res_t      res
);

    always_comb
    begin
        hec_pkg::res_t  r;
        hec_pkg::held_t h;
        hec_pkg::hexv_t hv;
        logic           absorbed;
        logic           brk;

        r        = '0;
        h        = held;
        hv       = hec_pkg::hex_val(in_byte);
        absorbed = 1'b0;
        brk      = 1'b0;

        if (direction)
        begin
            unique case (held.count)
                hec_pkg::HELD_IDLE:
                begin
                    brk = 1'b0;
                end
                hec_pkg::HELD_BS:
                begin
                    if (in_byte == hec_pkg::CH_X)
                    begin
                        h.count  = hec_pkg::HELD_BSX;
                        absorbed = 1'b1;
                    end
                    else
                        brk = 1'b1;
                end
                hec_pkg::HELD_BSX:
                begin
                    if (hv.ok)
                    begin
                        h.count      = hec_pkg::HELD_DIGIT;
                        h.nibble     = hv.val;
                        h.digit_byte = in_byte;
                        absorbed     = 1'b1;
                    end
                    else
                        brk = 1'b1;
                end
                hec_pkg::HELD_DIGIT:
                begin
                    if (hv.ok)
                    begin
                        r        = hec_pkg::push(r, {held.nibble, hv.val});
                        h.count  = hec_pkg::HELD_IDLE;
                        absorbed = 1'b1;
                    end
                    else
                        brk = 1'b1;
                end
            endcase

            // broken escape: held bytes go out literally
            if (brk)
            begin
                if (h.count != hec_pkg::HELD_IDLE)
                    r = hec_pkg::push(r, hec_pkg::CH_BSLASH);
                if (h.count == hec_pkg::HELD_BSX || h.count == hec_pkg::HELD_DIGIT)
                    r = hec_pkg::push(r, hec_pkg::CH_X);
                if (h.count == hec_pkg::HELD_DIGIT)
                    r = hec_pkg::push(r, h.digit_byte);
                h.count = hec_pkg::HELD_IDLE;
            end

            if (!absorbed)
            begin
                if (in_byte == hec_pkg::CH_BSLASH)
                    h.count = hec_pkg::HELD_BS;
                else if (in_byte == hec_pkg::CH_DASH)
                    r = hec_pkg::push(r, hec_pkg::CH_SLASH);
                else
                    r = hec_pkg::push(r, in_byte);
            end

            // end of string flushes whatever is still held
            if (in_last)
            begin
                if (h.count != hec_pkg::HELD_IDLE)
                    r = hec_pkg::push(r, hec_pkg::CH_BSLASH);
                if (h.count == hec_pkg::HELD_BSX || h.count == hec_pkg::HELD_DIGIT)
                    r = hec_pkg::push(r, hec_pkg::CH_X);
                if (h.count == hec_pkg::HELD_DIGIT)
                    r = hec_pkg::push(r, h.digit_byte);
                h.count = hec_pkg::HELD_IDLE;
            end
        end
        else
        begin
            h.count = hec_pkg::HELD_IDLE;
            if (in_byte == hec_pkg::CH_SLASH)
                r = hec_pkg::push(r, hec_pkg::CH_DASH);
            else if (hec_pkg::passes(in_byte))
                r = hec_pkg::push(r, in_byte);
            else
            begin
                r = hec_pkg::push(r, hec_pkg::CH_BSLASH);
                r = hec_pkg::push(r, hec_pkg::CH_X);
                r = hec_pkg::push(r, hec_pkg::hex_char(in_byte[7:4]));
                r = hec_pkg::push(r, hec_pkg::hex_char(in_byte[3:0]));
            end
        end

        r.last    = in_last;
        held_next = h;
        res       = r;
    end

endmodule

// ===== design/hec_outq.sv =====
// result register: holds one item's output bytes and hands them out one per cycle while out_ready is high
module hec_outq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hec_pkg::res_t     res,
    output logic              load_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              out_last
);

    logic [hec_pkg::MAX_OUT-1:0][7:0] bytes_reg;
    logic [hec_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [hec_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic                             last_reg;
    logic                             pop;

    assign pop        = out_valid && out_ready;
    assign out_valid  = cnt_reg != '0;
    assign out_byte   = bytes_reg[idx_reg];
    assign out_last   = last_reg && (cnt_reg == hec_pkg::CNT_W'(1));
    // free when empty, or once the last pending byte leaves in this cycle
    assign load_ready = (cnt_reg == '0) || ((cnt_reg == hec_pkg::CNT_W'(1)) && out_ready);

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = res.cnt;
            idx_next = '0;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - hec_pkg::CNT_W'(1);
            idx_next = idx_reg + hec_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= res.bytes;
            last_reg  <= res.last;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hec_pkg::CNT_W'(hec_pkg::MAX_OUT))
        else $error("pending byte count above limit");

    a_idx_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cnt_reg} + {{(hec_pkg::CNT_W + 1 - hec_pkg::IDX_W){1'b0}}, idx_reg})
            <= (hec_pkg::CNT_W + 1)'(hec_pkg::MAX_OUT))
        else $error("read index runs past loaded bytes");

    a_load_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (cnt_reg == $past(res.cnt)) && (idx_reg == '0))
        else $error("load did not take the new count");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && !load) |=> $stable(cnt_reg) && $stable(idx_reg))
        else $error("pending bytes moved during a stall");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cnt_reg == '0) || (pop && cnt_reg == hec_pkg::CNT_W'(1)))
        else $error("load overwrote bytes not yet transferred");

endmodule
